@@ rtl/refcounted_page_op_hash_table_defines.svh @@
// Assertion macros for the refcounted page-op hash table.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef REFCOUNTED_PAGE_OP_HASH_TABLE_DEFINES_SVH
`define REFCOUNTED_PAGE_OP_HASH_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RPHT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rpht check failed");
// next-cycle implication
`define RPHT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rpht check failed");
`else
`define RPHT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RPHT_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/rpht_pkg.sv @@
// Shared types and constants for the refcounted page-op hash table.
// No dependencies.
`timescale 1ns / 1ps
package rpht_pkg;

    localparam int BUCKETS_DEF    = 32;
    localparam int ENTRIES_DEF    = 64;
    localparam int PAGE_SHIFT_DEF = 12;

    localparam int HASH_W   = 10;   // widest bucket index over the bucket count range
    localparam int S_DATA_W = 88;
    localparam int M_DATA_W = 40;
    localparam logic [15:0] REF_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        FN_GET     = 2'd0,
        FN_CHECK   = 2'd1,
        FN_RELEASE = 2'd2,
        FN_NONE    = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        ST_CREATED   = 4'd0,
        ST_FOUND     = 4'd1,
        ST_ABSENT    = 4'd2,
        ST_REFUSED   = 4'd3,
        ST_FULL      = 4'd4,
        ST_KEPT      = 4'd5,
        ST_FREED     = 4'd6,
        ST_BADHANDLE = 4'd7,
        ST_SATURATED = 4'd8
    } status_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_HASH,
        F_PUSH
    } fstate_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_DISP,
        B_FIND_RD,
        B_FIND_CHK,
        B_SCAN,
        B_REL_CHK,
        B_UNL_RD,
        B_UNL_CHK,
        B_OUT
    } bstate_t;

    typedef struct packed {
        func_t             func;
        logic              key_kind;
        logic [31:0]       key_high;
        logic [31:0]       key_low;
        logic [7:0]        op_kind;
        logic              first_only;
        logic [5:0]        handle;
        logic [HASH_W-1:0] bucket;
    } cmd_t;

endpackage

@@ rtl/rpht_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module rpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/rpht_front.sv @@
// Front end: accepts items, unpacks them and computes the bucket index.
// Depends on rpht_pkg.
`timescale 1ns / 1ps
module rpht_front #(
    parameter int BUCKETS    = rpht_pkg::BUCKETS_DEF,
    parameter int PAGE_SHIFT = rpht_pkg::PAGE_SHIFT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rpht_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [0:0]                    s_tuser,
    output logic                          q_valid,
    input  logic                          q_ready,
    output rpht_pkg::cmd_t                q_cmd
);

    localparam int BWF = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int LW  = $clog2(BUCKETS);
    // ceil(2^(32+LW) / BUCKETS): exact quotient for every 32-bit dividend
    localparam longint unsigned RECIP =
        ((64'd1 << (32 + LW)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
    localparam logic [32:0] RECIP_C = 33'(RECIP);

    rpht_pkg::fstate_t state_reg, state_next;
    rpht_pkg::cmd_t    cmd_reg, cmd_next;
    logic [31:0]       val_reg, val_next;
    logic [31:0]       quo_reg, quo_next;
    logic [2:0]        cnt_reg, cnt_next;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rpht_pkg::F_IDLE: begin
                if (s_tvalid) state_next = rpht_pkg::F_HASH;
            end
            rpht_pkg::F_HASH: begin
                if (cnt_reg == 3'd1) state_next = rpht_pkg::F_PUSH;
            end
            rpht_pkg::F_PUSH: begin
                if (q_ready) state_next = rpht_pkg::F_IDLE;
            end
            default: state_next = rpht_pkg::F_IDLE;
        endcase
    end

    // outputs and datapath; bucket = value mod BUCKETS: reciprocal
    // multiply for the quotient, then multiply back and subtract
    always_comb begin
        logic [64:0] prod;
        logic [31:0] diff;
        s_tready = 1'b0;
        q_valid  = 1'b0;
        cmd_next = cmd_reg;
        val_next = val_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        prod = '0;
        diff = '0;
        case (state_reg)
            rpht_pkg::F_IDLE: begin
                s_tready            = 1'b1;
                cmd_next.func       = rpht_pkg::func_t'(s_tdata[1:0]);
                cmd_next.key_kind   = s_tuser[0];
                cmd_next.key_high   = s_tdata[33:2];
                cmd_next.key_low    = s_tdata[65:34];
                cmd_next.op_kind    = s_tdata[73:66];
                cmd_next.first_only = s_tdata[74];
                cmd_next.handle     = s_tdata[80:75];
                cmd_next.bucket     = '0;
                val_next = s_tdata[33:2] | (s_tdata[65:34] >> PAGE_SHIFT);
                cnt_next = '0;
            end
            rpht_pkg::F_HASH: begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd0) begin
                    prod     = 65'(val_reg) * 65'(RECIP_C);
                    quo_next = 32'(prod >> (32 + LW));
                end else begin
                    diff = val_reg - quo_reg * 32'(BUCKETS);
                    cmd_next.bucket = rpht_pkg::HASH_W'(diff[BWF-1:0]);
                end
            end
            rpht_pkg::F_PUSH: begin
                q_valid = 1'b1;
            end
            default: ;
        endcase
    end

    assign q_cmd = cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rpht_pkg::F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cmd_reg <= cmd_next;
        val_reg <= val_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

endmodule

@@ rtl/rpht_queue.sv @@
// Two-deep command queue between the front end and the table engine.
// Depends on rpht_pkg.
`timescale 1ns / 1ps
module rpht_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  rpht_pkg::cmd_t in_cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output rpht_pkg::cmd_t out_cmd
);

    rpht_pkg::cmd_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_cmd   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

@@ rtl/rpht_back.sv @@
// Table engine: chain walks, allocation, reference counting and unlinking.
// Depends on rpht_pkg, rpht_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "refcounted_page_op_hash_table_defines.svh"
module rpht_back #(
    parameter int BUCKETS = rpht_pkg::BUCKETS_DEF,
    parameter int ENTRIES = rpht_pkg::ENTRIES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  rpht_pkg::cmd_t                cmd,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rpht_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int IW     = $clog2(ENTRIES);
    localparam int BW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int GROUPS = (ENTRIES + 7) / 8;
    localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    typedef struct packed {
        logic          kind;
        logic [31:0]   key_high;
        logic [31:0]   key_low;
        logic [15:0]   refs;
        logic          nok;
        logic [IW-1:0] nxt;
        logic [BW-1:0] bkt;
        logic [7:0]    op;
    } entry_t;

    localparam int EW = $bits(entry_t);

    rpht_pkg::bstate_t state_reg, state_next;
    rpht_pkg::cmd_t    cmd_reg, cmd_next;
    logic [IW-1:0]     cur_reg, cur_next;
    logic              ok_reg, ok_next;
    logic [GW-1:0]     grp_reg, grp_next;
    logic [IW-1:0]     vnxt_reg, vnxt_next;
    logic              vnok_reg, vnok_next;
    rpht_pkg::status_t st_reg, st_next;
    logic [5:0]        rh_reg, rh_next;
    logic [15:0]       rc_reg, rc_next;
    logic [7:0]        op_reg, op_next;

    logic [IW-1:0]     head_reg [BUCKETS];
    logic [BUCKETS-1:0] head_ok_reg;
    logic [ENTRIES-1:0] valid_reg;

    logic              ram_we;
    logic [IW-1:0]     ram_waddr, ram_raddr;
    entry_t            ram_wdata, rd;
    logic [EW-1:0]     ram_rdata;

    logic              head_we;
    logic [BW-1:0]     head_idx;
    logic [IW-1:0]     head_val;
    logic              head_ok_val;
    logic              valid_set, valid_clr;
    logic [IW-1:0]     valid_idx;

    logic [BW-1:0]     bkt_cmd;
    logic [15:0]       hwide;
    logic [IW-1:0]     hidx;
    logic              bad_handle, hit, unl_hit, head_is_victim;
    logic [GROUPS*8-1:0] vpad;
    logic [7:0]        gbits;
    logic              free_found, last_grp;
    logic [2:0]        fk;
    logic [GW+2:0]     fsum;
    logic [IW-1:0]     fidx;

    rpht_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_entries (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd      = entry_t'(ram_rdata);
    assign bkt_cmd = cmd_reg.bucket[BW-1:0];
    assign hwide   = 16'(cmd_reg.handle);
    assign hidx    = hwide[IW-1:0];
    assign bad_handle = (hwide >= 16'(ENTRIES)) || !valid_reg[hidx];
    assign hit = valid_reg[cur_reg] && (rd.kind == cmd_reg.key_kind)
                 && (rd.key_high == cmd_reg.key_high) && (rd.key_low == cmd_reg.key_low);
    assign unl_hit = rd.nok && (rd.nxt == hidx);
    assign head_is_victim = head_ok_reg[rd.bkt] && (head_reg[rd.bkt] == hidx);

    // free slot search, eight valid bits per cycle
    always_comb begin
        vpad = '1;
        vpad[ENTRIES-1:0] = valid_reg;
        gbits = vpad[grp_reg*8 +: 8];
        free_found = 1'b0;
        fk = 3'd0;
        for (int k = 7; k >= 0; k--) begin
            if (!gbits[k]) begin
                free_found = 1'b1;
                fk = 3'(k);
            end
        end
    end
    assign fsum     = {grp_reg, fk};
    assign fidx     = fsum[IW-1:0];
    assign last_grp = (grp_reg == GW'(GROUPS - 1));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rpht_pkg::B_IDLE: begin
                if (cmd_valid) state_next = rpht_pkg::B_DISP;
            end
            rpht_pkg::B_DISP: begin
                case (cmd_reg.func)
                    rpht_pkg::FN_GET,
                    rpht_pkg::FN_CHECK: state_next = rpht_pkg::B_FIND_RD;
                    rpht_pkg::FN_RELEASE: begin
                        state_next = bad_handle ? rpht_pkg::B_OUT : rpht_pkg::B_REL_CHK;
                    end
                    default: state_next = rpht_pkg::B_OUT;
                endcase
            end
            rpht_pkg::B_FIND_RD: begin
                if (ok_reg) state_next = rpht_pkg::B_FIND_CHK;
                else if (cmd_reg.func == rpht_pkg::FN_GET) state_next = rpht_pkg::B_SCAN;
                else state_next = rpht_pkg::B_OUT;
            end
            rpht_pkg::B_FIND_CHK: begin
                state_next = hit ? rpht_pkg::B_OUT : rpht_pkg::B_FIND_RD;
            end
            rpht_pkg::B_SCAN: begin
                if (free_found || last_grp) state_next = rpht_pkg::B_OUT;
            end
            rpht_pkg::B_REL_CHK: begin
                if (rd.refs > 16'd1 || head_is_victim) state_next = rpht_pkg::B_OUT;
                else state_next = rpht_pkg::B_UNL_RD;
            end
            rpht_pkg::B_UNL_RD: begin
                state_next = ok_reg ? rpht_pkg::B_UNL_CHK : rpht_pkg::B_OUT;
            end
            rpht_pkg::B_UNL_CHK: begin
                state_next = unl_hit ? rpht_pkg::B_OUT : rpht_pkg::B_UNL_RD;
            end
            rpht_pkg::B_OUT: begin
                if (m_tready) state_next = rpht_pkg::B_IDLE;
            end
            default: state_next = rpht_pkg::B_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        cmd_ready   = 1'b0;
        m_tvalid    = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = cur_reg;
        ram_wdata   = rd;
        ram_raddr   = cur_reg;
        head_we     = 1'b0;
        head_idx    = bkt_cmd;
        head_val    = fidx;
        head_ok_val = 1'b1;
        valid_set   = 1'b0;
        valid_clr   = 1'b0;
        valid_idx   = hidx;
        cmd_next    = cmd_reg;
        cur_next    = cur_reg;
        ok_next     = ok_reg;
        grp_next    = grp_reg;
        vnxt_next   = vnxt_reg;
        vnok_next   = vnok_reg;
        st_next     = st_reg;
        rh_next     = rh_reg;
        rc_next     = rc_reg;
        op_next     = op_reg;
        case (state_reg)
            rpht_pkg::B_IDLE: begin
                cmd_ready = 1'b1;
                cmd_next  = cmd;
            end
            rpht_pkg::B_DISP: begin
                cur_next  = head_reg[bkt_cmd];
                ok_next   = head_ok_reg[bkt_cmd];
                grp_next  = '0;
                ram_raddr = hidx;
                st_next   = rpht_pkg::ST_ABSENT;
                rh_next   = '0;
                rc_next   = '0;
                op_next   = '0;
                if (cmd_reg.func == rpht_pkg::FN_RELEASE && bad_handle) begin
                    st_next = rpht_pkg::ST_BADHANDLE;
                    rh_next = cmd_reg.handle;
                end
            end
            rpht_pkg::B_FIND_RD: begin
                // end of chain: a check reports absent, a get goes on to allocate
                if (!ok_reg) begin
                    st_next = rpht_pkg::ST_ABSENT;
                end
            end
            rpht_pkg::B_FIND_CHK: begin
                cur_next = rd.nxt;
                ok_next  = rd.nok;
                if (hit) begin
                    rh_next = 6'(cur_reg);
                    op_next = rd.op;
                    rc_next = rd.refs;
                    if (cmd_reg.func == rpht_pkg::FN_GET && cmd_reg.first_only) begin
                        st_next = rpht_pkg::ST_REFUSED;
                    end else if (rd.refs == rpht_pkg::REF_MAX) begin
                        st_next = rpht_pkg::ST_SATURATED;
                    end else begin
                        st_next        = rpht_pkg::ST_FOUND;
                        rc_next        = rd.refs + 16'd1;
                        ram_we         = 1'b1;
                        ram_wdata.refs = rd.refs + 16'd1;
                    end
                end
            end
            rpht_pkg::B_SCAN: begin
                grp_next = grp_reg + GW'(1);
                if (free_found) begin
                    ram_we             = 1'b1;
                    ram_waddr          = fidx;
                    ram_wdata.kind     = cmd_reg.key_kind;
                    ram_wdata.key_high = cmd_reg.key_high;
                    ram_wdata.key_low  = cmd_reg.key_low;
                    ram_wdata.refs     = 16'd1;
                    ram_wdata.nok      = head_ok_reg[bkt_cmd];
                    ram_wdata.nxt      = head_reg[bkt_cmd];
                    ram_wdata.bkt      = bkt_cmd;
                    ram_wdata.op       = cmd_reg.op_kind;
                    head_we   = 1'b1;
                    valid_set = 1'b1;
                    valid_idx = fidx;
                    st_next   = rpht_pkg::ST_CREATED;
                    rh_next   = 6'(fidx);
                    rc_next   = 16'd1;
                    op_next   = cmd_reg.op_kind;
                end else if (last_grp) begin
                    st_next = rpht_pkg::ST_FULL;
                end
            end
            rpht_pkg::B_REL_CHK: begin
                rh_next   = cmd_reg.handle;
                op_next   = rd.op;
                vnxt_next = rd.nxt;
                vnok_next = rd.nok;
                cur_next  = head_reg[rd.bkt];
                ok_next   = head_ok_reg[rd.bkt];
                if (rd.refs > 16'd1) begin
                    st_next        = rpht_pkg::ST_KEPT;
                    rc_next        = rd.refs - 16'd1;
                    ram_we         = 1'b1;
                    ram_waddr      = hidx;
                    ram_wdata.refs = rd.refs - 16'd1;
                end else begin
                    st_next   = rpht_pkg::ST_FREED;
                    rc_next   = '0;
                    valid_clr = 1'b1;
                    // victim at the chain head: unlink by moving the head
                    if (head_is_victim) begin
                        head_we     = 1'b1;
                        head_idx    = rd.bkt;
                        head_val    = rd.nxt;
                        head_ok_val = rd.nok;
                    end
                end
            end
            rpht_pkg::B_UNL_RD: ;
            rpht_pkg::B_UNL_CHK: begin
                cur_next = rd.nxt;
                ok_next  = rd.nok;
                if (unl_hit) begin
                    ram_we        = 1'b1;
                    ram_wdata.nxt = vnxt_reg;
                    ram_wdata.nok = vnok_reg;
                end
            end
            rpht_pkg::B_OUT: begin
                m_tvalid = 1'b1;
            end
            default: ;
        endcase
    end

    // m_tdata: status[3:0], result_handle[9:4], ref_count[25:10], stored_op_kind[33:26]
    assign m_tdata = {6'd0, op_reg, rc_reg, rh_reg, st_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rpht_pkg::B_IDLE;
            head_ok_reg <= '0;
            valid_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (head_we) begin
                head_ok_reg[head_idx] <= head_ok_val;
            end
            if (valid_set) begin
                valid_reg[valid_idx] <= 1'b1;
            end else if (valid_clr) begin
                valid_reg[valid_idx] <= 1'b0;
            end
        end
        if (head_we) begin
            head_reg[head_idx] <= head_val;
        end
        cmd_reg  <= cmd_next;
        cur_reg  <= cur_next;
        ok_reg   <= ok_next;
        grp_reg  <= grp_next;
        vnxt_reg <= vnxt_next;
        vnok_reg <= vnok_next;
        st_reg   <= st_next;
        rh_reg   <= rh_next;
        rc_reg   <= rc_next;
        op_reg   <= op_next;
    end

    `RPHT_ASSERT_IMP(a_created_one, aclk, aresetn, m_tvalid && st_reg == rpht_pkg::ST_CREATED, rc_reg == 16'd1)
    `RPHT_ASSERT_IMP(a_fail_zero, aclk, aresetn, m_tvalid && (st_reg == rpht_pkg::ST_ABSENT || st_reg == rpht_pkg::ST_FULL || st_reg == rpht_pkg::ST_BADHANDLE), rc_reg == 16'd0 && op_reg == 8'd0)
    `RPHT_ASSERT_NXT(a_create_marks, aclk, aresetn, state_reg == rpht_pkg::B_SCAN && free_found, valid_reg[$past(fidx)])
    `RPHT_ASSERT_NXT(a_one_result, aclk, aresetn, m_tvalid && m_tready, !m_tvalid && cmd_ready)

endmodule

@@ rtl/refcounted_page_op_hash_table.sv @@
// Top level of the refcounted page-op hash table.
// Depends on rpht_pkg, rpht_front, rpht_queue and rpht_back.
`timescale 1ns / 1ps
// Usage:
//   s_ channel: one request item per handshake (get/create, check and
//   reference, release). m_ channel: exactly one result item per request,
//   in request order.
//   Front end takes an item in its idle state, computes the bucket
//   remainder (reciprocal multiply, then multiply back and subtract),
//   then pushes a command into a two-deep queue; it takes no new item
//   until that push is done, and waits there while the queue is full.
//   Table engine: pops and dispatches a command, reads and checks each
//   chain entry visited (entry RAM with registered read), notes the end
//   of a chain, scans the valid bits eight per group for a free slot on
//   a create, up to ceil(ENTRIES/8) groups, walks the chain again on a
//   release that frees a non-head entry, and holds the result in the
//   output register.
//   Reset clears the bucket head valid bits and all entry valid bits at
//   once; the table is usable in the first cycle after reset.
//   When m_tready is low the result holds in its register; the queue
//   absorbs up to two further commands, the front end holds one more, and
//   s_tready stays low until the front end is idle again.
module refcounted_page_op_hash_table #(
    parameter int BUCKETS    = rpht_pkg::BUCKETS_DEF,
    parameter int ENTRIES    = rpht_pkg::ENTRIES_DEF,
    parameter int PAGE_SHIFT = rpht_pkg::PAGE_SHIFT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // func[1:0], key_high[33:2], key_low[65:34], op_kind[73:66],
    // first_only[74], handle[80:75], zero pad above
    input  logic [rpht_pkg::S_DATA_W-1:0] s_tdata,
    // key_kind[0]
    input  logic [0:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status[3:0], result_handle[9:4], ref_count[25:10],
    // stored_op_kind[33:26], zero pad above
    output logic [rpht_pkg::M_DATA_W-1:0] m_tdata
);

    rpht_pkg::cmd_t fq_cmd, qb_cmd;
    logic           fq_valid, fq_ready;
    logic           qb_valid, qb_ready;

    rpht_front #(.BUCKETS(BUCKETS), .PAGE_SHIFT(PAGE_SHIFT)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_cmd    (fq_cmd)
    );

    rpht_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_cmd    (fq_cmd),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_cmd   (qb_cmd)
    );

    rpht_back #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (qb_valid),
        .cmd_ready (qb_ready),
        .cmd       (qb_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

@@ tb/rpht_checker.sv @@
// Checker for the refcounted page-op hash table: watches both streams, predicts, compares.
// Depends on rpht_pkg.
`timescale 1ns / 1ps
module rpht_checker
    import rpht_pkg::*;
#(
    parameter int BUCKETS    = 32,
    parameter int ENTRIES    = 64,
    parameter int PAGE_SHIFT = 12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [0:0]          s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    output int                  fail_count,
    output int                  pending
);

    typedef struct packed {
        status_t     status;
        logic [5:0]  hnd;
        logic [15:0] refs;
        logic [7:0]  op;
    } answer_t;

    // table mirror; -1 marks an empty link
    int          head_of[BUCKETS];
    bit          live[ENTRIES];
    bit          kind_of[ENTRIES];
    logic [31:0] hi_of[ENTRIES];
    logic [31:0] lo_of[ENTRIES];
    logic [15:0] refs_of[ENTRIES];
    int          next_of[ENTRIES];
    int          bkt_of[ENTRIES];
    logic [7:0]  op_of[ENTRIES];

    answer_t answers_due[$];

    initial begin
        fail_count = 0;
        foreach (head_of[i]) head_of[i] = -1;
        foreach (live[i]) begin
            live[i]    = 0;
            next_of[i] = -1;
        end
    end

    assign pending = answers_due.size();

    function automatic int lookup(int b, bit k, logic [31:0] hi, logic [31:0] lo);
        int cur;
        cur = head_of[b];
        for (int n = 0; n < ENTRIES && cur >= 0; n++) begin
            if (live[cur] && kind_of[cur] == k && hi_of[cur] == hi && lo_of[cur] == lo)
                return cur;
            cur = next_of[cur];
        end
        return -1;
    endfunction

    function automatic void unlink(int i);
        int b;
        int cur;
        b = bkt_of[i];
        if (head_of[b] == i) begin
            head_of[b] = next_of[i];
        end else begin
            cur = head_of[b];
            for (int n = 0; n < ENTRIES && cur >= 0; n++) begin
                if (next_of[cur] == i) begin
                    next_of[cur] = next_of[i];
                    break;
                end
                cur = next_of[cur];
            end
        end
        live[i]    = 0;
        next_of[i] = -1;
    endfunction

    function automatic answer_t apply_request(logic [S_DATA_W-1:0] d, bit k);
        func_t       fn;
        logic [31:0] hi;
        logic [31:0] lo;
        logic [7:0]  op;
        bit          first;
        int          h;
        int          b;
        int          idx;
        answer_t     a;
        fn    = func_t'(d[1:0]);
        hi    = d[33:2];
        lo    = d[65:34];
        op    = d[73:66];
        first = d[74];
        h     = d[80:75];
        b     = (hi | (lo >> PAGE_SHIFT)) % BUCKETS;
        a     = '{ST_ABSENT, 6'd0, 16'd0, 8'd0};
        case (fn)
            FN_GET, FN_CHECK: begin
                idx = lookup(b, k, hi, lo);
                if (idx >= 0) begin
                    if (fn == FN_GET && first) begin
                        a = '{ST_REFUSED, 6'(idx), refs_of[idx], op_of[idx]};
                    end else if (refs_of[idx] == REF_MAX) begin
                        a = '{ST_SATURATED, 6'(idx), REF_MAX, op_of[idx]};
                    end else begin
                        refs_of[idx]++;
                        a = '{ST_FOUND, 6'(idx), refs_of[idx], op_of[idx]};
                    end
                end else if (fn == FN_GET) begin
                    idx = -1;
                    for (int i = 0; i < ENTRIES; i++)
                        if (!live[i]) begin
                            idx = i;
                            break;
                        end
                    if (idx < 0) begin
                        a = '{ST_FULL, 6'd0, 16'd0, 8'd0};
                    end else begin
                        live[idx]    = 1;
                        kind_of[idx] = k;
                        hi_of[idx]   = hi;
                        lo_of[idx]   = lo;
                        refs_of[idx] = 16'd1;
                        op_of[idx]   = op;
                        bkt_of[idx]  = b;
                        next_of[idx] = head_of[b];
                        head_of[b]   = idx;
                        a = '{ST_CREATED, 6'(idx), 16'd1, op};
                    end
                end
            end
            FN_RELEASE: begin
                if (h >= ENTRIES || !live[h]) begin
                    a = '{ST_BADHANDLE, 6'(h), 16'd0, 8'd0};
                end else if (refs_of[h] > 1) begin
                    refs_of[h]--;
                    a = '{ST_KEPT, 6'(h), refs_of[h], op_of[h]};
                end else begin
                    refs_of[h] = 0;
                    unlink(h);
                    a = '{ST_FREED, 6'(h), 16'd0, op_of[h]};
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    task automatic report(string what, int got, int want);
        $display("%0t: %s got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        answer_t want;
        if (aresetn) begin
            // older result first, then the new request
            if (m_tvalid && m_tready) begin
                if (answers_due.size() == 0) begin
                    report("unexpected result, status", m_tdata[3:0], -1);
                end else begin
                    want = answers_due.pop_front();
                    if (m_tdata[3:0] != want.status)
                        report("status", m_tdata[3:0], want.status);
                    if (m_tdata[9:4] != want.hnd)
                        report("result_handle", m_tdata[9:4], want.hnd);
                    if (m_tdata[25:10] != want.refs)
                        report("ref_count", m_tdata[25:10], want.refs);
                    if (m_tdata[33:26] != want.op)
                        report("stored_op_kind", m_tdata[33:26], want.op);
                end
            end
            if (s_tvalid && s_tready)
                answers_due.push_back(apply_request(s_tdata, s_tuser[0]));
        end
    end

endmodule

@@ tb/tb_top.sv @@
// Top of the refcounted page-op hash table testbench: clock, reset, stimulus, verdict.
// Depends on rpht_pkg, refcounted_page_op_hash_table and rpht_checker.
`timescale 1ns / 1ps
module tb_top;
    import rpht_pkg::*;

    localparam int KEYS = 96;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    // func[1:0], key_high[33:2], key_low[65:34], op_kind[73:66],
    // first_only[74], handle[80:75], zero pad above
    logic [S_DATA_W-1:0] s_tdata;
    // key_kind[0]
    logic [0:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    // status[3:0], result_handle[9:4], ref_count[25:10],
    // stored_op_kind[33:26], zero pad above
    logic [M_DATA_W-1:0] m_tdata;
    int                  fail_count;
    int                  pending;

    // idle percentages per side, changed between phases
    int send_idle_pct;
    int recv_stall_pct;

    // key pool: shared keys give hits, chains and a full table
    logic [31:0] pool_hi[KEYS];
    logic [31:0] pool_lo[KEYS];
    bit          pool_kind[KEYS];

    refcounted_page_op_hash_table dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    rpht_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    // receiver: one decision per edge
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // one item; valid stays up across back-to-back items
    task automatic send(func_t fn, bit k, logic [31:0] hi, logic [31:0] lo,
                        logic [7:0] op, bit first, logic [5:0] h);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= {7'd0, h, first, op, lo, hi, fn};
        s_tuser  <= k;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_key(func_t fn, int n, bit first);
        send(fn, pool_kind[n], pool_hi[n], pool_lo[n], 8'($urandom), first, 6'($urandom));
    endtask

    // fill burst, then a mix weighted toward gets
    task automatic random_phase(int count);
        int pick;
        int n;
        for (int i = 0; i < 70; i++)
            send_key(FN_GET, $urandom_range(KEYS - 1), 0);
        for (int i = 0; i < count - 70; i++) begin
            pick = $urandom_range(99);
            n    = $urandom_range(KEYS - 1);
            if (pick < 45)
                send_key(FN_GET, n, $urandom_range(3) == 0);
            else if (pick < 65)
                send_key(FN_CHECK, n, 1'($urandom_range(1)));
            else if (pick < 92)
                send_key(FN_RELEASE, n, 1'($urandom_range(1)));
            else if (pick < 96)
                send(FN_CHECK, 1'($urandom_range(1)), $urandom, $urandom, 8'($urandom), 0, 0);
            else
                send_key(FN_NONE, n, 1'($urandom_range(1)));
        end
    endtask

    initial begin
        int j;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        m_tready       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < KEYS; i++) begin
            if (i < 32) begin
                pool_hi[i]   = $urandom;
                pool_lo[i]   = $urandom;
                pool_kind[i] = 1'($urandom_range(1));
            end else if (i < 64) begin
                // low high-keys and few pages: crowded buckets
                pool_hi[i]   = $urandom_range(3);
                pool_lo[i]   = {17'd0, 3'($urandom), 12'($urandom)};
                pool_kind[i] = 1'($urandom_range(1));
            end else begin
                // same key, other kind
                j            = i - 64;
                pool_hi[i]   = pool_hi[j];
                pool_lo[i]   = pool_lo[j];
                pool_kind[i] = !pool_kind[j];
            end
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: create, hit, refuse, kind mismatch, chain unlink, bad handle
        send(FN_GET, 1, '1, '1, 8'hFF, 0, 0);              // created, handle 0
        send(FN_GET, 1, '1, '1, 8'h00, 0, 0);              // found, count 2
        send(FN_GET, 1, '1, '1, 8'h00, 1, 0);              // refused
        send(FN_CHECK, 1, '1, '1, 8'h00, 0, 0);            // found, count 3
        send(FN_CHECK, 0, '1, '1, 8'h00, 0, 0);            // other kind: absent
        send(FN_GET, 0, 32'd0, 32'd0, 8'h00, 0, 0);        // created, handle 1, bucket 0
        send(FN_GET, 0, 32'd0, 32'h0002_0000, 8'h5A, 0, 0); // same bucket, chain head
        send(FN_GET, 1, 32'd0, 32'h0004_0000, 8'hA5, 0, 0); // third in bucket 0
        send(FN_CHECK, 0, 32'd0, 32'd0, 8'h00, 0, 0);      // found at chain tail
        send(FN_RELEASE, 0, 0, 0, 0, 0, 6'd2);             // free middle entry
        send(FN_RELEASE, 0, 0, 0, 0, 0, 6'd1);             // kept
        send(FN_RELEASE, 0, 0, 0, 0, 0, 6'd1);             // freed, tail of chain
        send(FN_CHECK, 1, 32'd0, 32'h0004_0000, 8'h00, 0, 0); // still reachable
        send(FN_RELEASE, 0, 0, 0, 0, 0, 6'd63);            // bad handle, free entry
        send(FN_RELEASE, 0, 0, 0, 0, 0, 6'd2);             // bad handle, just freed
        send(FN_NONE, 1, '1, '1, 8'hFF, 1, 6'd63);         // unknown func
        send(FN_CHECK, 0, 32'h1234_5678, 32'h9ABC_DEF0, 8'h00, 0, 0); // absent
        send(FN_GET, 0, 32'd0, 32'h0002_0000, 8'h00, 0, 0); // reuses lowest free slot
        for (int i = 0; i < 4; i++)
            send(FN_RELEASE, 0, 0, 0, 0, 0, 6'd0);         // kept, kept, freed, bad
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);

        send_idle_pct  = 28;
        recv_stall_pct = 64;
        random_phase(650);
        send_idle_pct  = 64;
        recv_stall_pct = 28;
        random_phase(650);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_phase(650);
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #40_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ refcounted_page_op_hash_table.f @@
+incdir+rtl
rtl/rpht_pkg.sv
rtl/rpht_ram.sv
rtl/rpht_front.sv
rtl/rpht_queue.sv
rtl/rpht_back.sv
rtl/refcounted_page_op_hash_table.sv
tb/rpht_checker.sv
tb/tb_top.sv
